>>> src/mpq_pkg.sv
// ============================================================================
// mpq_pkg: shared types and codes for the max priority queue
// Request and response payloads, the slot entry and the control word that
// the queue controller broadcasts to every slot cell.
// ============================================================================
package mpq_pkg;

    localparam logic CMD_ADD     = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_HOLD   = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd2;

    localparam int COUNT_OUT_W = 7;

    typedef struct packed {
        logic               cmd;
        logic [31:0]        key;
        logic signed [31:0] priority_req;
    } req_t;

    typedef struct packed {
        logic                   ok;
        logic [31:0]            out_key;
        logic signed [31:0]     out_priority;
        logic [COUNT_OUT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic [31:0]        key;
        logic signed [31:0] prio;
    } entry_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        entry_t          ent;
    } cell_ctrl_t;

endpackage

>>> src/mpq_cell.sv
// ============================================================================
// mpq_cell: one slot of the sorted queue
// Holds one entry, compares it with the broadcast entry and takes its own
// next value from itself, a neighbor or the broadcast entry.
// ============================================================================
module mpq_cell (
    input  logic               clk,
    input  mpq_pkg::cell_ctrl_t ctrl,
    input  logic               live,
    input  logic               chain_in,
    output logic               chain_out,
    input  logic               lt_in,
    output logic               lt_out,
    input  mpq_pkg::entry_t    left_ent,
    input  mpq_pkg::entry_t    right_ent,
    output mpq_pkg::entry_t    ent
);
    import mpq_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;
    logic   match;
    logic   lt_self;

    assign match     = live && (ent_reg.key == ctrl.ent.key);
    assign lt_self   = live && (ctrl.ent.prio < ent_reg.prio);
    assign chain_out = chain_in || match;
    assign lt_out    = lt_self;
    assign ent       = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        case (ctrl.op)
            OP_REMOVE:
            begin
                if (chain_out)
                begin
                    ent_next = right_ent;
                end
            end
            OP_INSERT:
            begin
                if (!lt_self)
                begin
                    ent_next = lt_in ? ctrl.ent : left_ent;
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

>>> src/max_priority_queue_with_key_update.sv
// ============================================================================
// max_priority_queue_with_key_update: sorted max priority queue
// A row of slot cells kept in descending priority order. An add removes any
// entry with the same key and then inserts ahead of equal priorities; a
// dequeue pops the head slot.
//
// Channel   Direction   Handshake              Payload
// req       in          req_valid/req_ready    req_t  (cmd, key, priority_req)
// rsp       out         rsp_valid/rsp_ready    rsp_t  (ok, key, priority, count)
//
// A dequeue is a remove pass over the row in the accept cycle. An add does
// that remove pass and then an insert pass in ST_INSERT, which waits for out_free.
// The row length CAPACITY sets the depth of the combinational match chain.
// Reset clears the fill count and handshake state; slots need no reset.
// A result waits in the output register while rsp_ready is low; a new
// request is taken only when that register can accept the next result.
// ============================================================================
module max_priority_queue_with_key_update #(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  mpq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output mpq_pkg::rsp_t rsp
);
    import mpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_INSERT = 1'b1;

    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    entry_t           pend_reg;
    entry_t           pend_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    cell_ctrl_t       ctrl;
    logic             out_free;
    logic             accept;
    logic             head_pop;
    logic             room;
    logic             chain [CAPACITY+1];
    logic             lt    [CAPACITY+1];
    entry_t           cell_ent [CAPACITY];

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req_valid && req_ready;
    assign head_pop  = accept && (req.cmd == CMD_DEQUEUE) && (count_reg != '0);
    assign room      = count_reg < CAP_CNT;

    assign chain[0] = head_pop;
    assign lt[0]    = 1'b1;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        mpq_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .live      (CNT_W'(i) < count_reg),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .lt_in     (lt[i]),
            .lt_out    (lt[i+1]),
            .left_ent  ((i == 0) ? ctrl.ent : cell_ent[(i == 0) ? 0 : i-1]),
            .right_ent (cell_ent[(i == CAPACITY-1) ? i : i+1]),
            .ent       (cell_ent[i])
        );
    end

    always_comb
    begin
        ctrl           = '{op: OP_HOLD, ent: pend_reg};
        state_next     = state_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.op       = OP_REMOVE;
                    ctrl.ent.key  = req.key;
                    ctrl.ent.prio = req.priority_req;
                    pend_next     = '{key: req.key, prio: req.priority_req};
                    if (chain[CAPACITY])
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    if (req.cmd == CMD_DEQUEUE)
                    begin
                        rsp_valid_next = 1'b1;
                        if (head_pop)
                        begin
                            rsp_next.ok           = 1'b1;
                            rsp_next.out_key      = cell_ent[0].key;
                            rsp_next.out_priority = cell_ent[0].prio;
                        end
                        else
                        begin
                            rsp_next.ok           = 1'b0;
                            rsp_next.out_key      = '0;
                            rsp_next.out_priority = '0;
                        end
                        rsp_next.entry_count = COUNT_OUT_W'(count_next);
                    end
                    else
                    begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_INSERT:
            begin
                if (out_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.out_key      = '0;
                    rsp_next.out_priority = '0;
                    rsp_next.ok           = room;
                    if (room)
                    begin
                        ctrl.op    = OP_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                    rsp_next.entry_count = COUNT_OUT_W'(count_next);
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
